@@ src/minmod_gradient_limiter_core_defines.svh @@
// Assertion helpers for the gradient limiter core.
`ifndef MINMOD_GRADIENT_LIMITER_CORE_DEFINES_SVH
`define MINMOD_GRADIENT_LIMITER_CORE_DEFINES_SVH

// Same-cycle implication.
`define MGL_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication.
`define MGL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

@@ src/mgl_pkg.sv @@
package mgl_pkg;

  localparam int MAX_NEIGHBORS_DEF   = 6;
  localparam int COMPONENT_COUNT_DEF = 8;
  localparam int NBR_FIELDS          = 6;

  localparam int SLOPE_W = 32;
  localparam int SIZE_W  = 31;
  localparam int THR_W   = 31;
  localparam int SCALE_W = 18;
  localparam int MEAN_W  = 31;
  localparam int SUM_W   = 40;
  localparam int DIFF_W  = 33;
  localparam int FRAC_W  = 16;

  localparam int PADDR_W     = 3;
  localparam int PDATA_W     = 32;
  localparam int REG_IDX_LSB = 2;

  localparam logic REG_LIMIT_THRESHOLD = 1'b0;
  localparam logic REG_NEIGHBOR_SCALE  = 1'b1;

  localparam logic [THR_W-1:0]   THRESHOLD_RESET = '0;
  localparam logic [SCALE_W-1:0] SCALE_RESET     = 18'h10000;

  localparam int QUEUE_DEPTH = 4;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic signed [SLOPE_W-1:0] own_slope;
    logic signed [SLOPE_W-1:0] nbr_slope_0;
    logic signed [SLOPE_W-1:0] nbr_slope_1;
    logic signed [SLOPE_W-1:0] nbr_slope_2;
    logic signed [SLOPE_W-1:0] nbr_slope_3;
    logic signed [SLOPE_W-1:0] nbr_slope_4;
    logic signed [SLOPE_W-1:0] nbr_slope_5;
    logic [NBR_FIELDS-1:0]     nbr_present;
    logic [SIZE_W-1:0]         cell_size;
    logic                      cell_end;
  } item_t;

  typedef struct packed {
    logic signed [SLOPE_W-1:0] limited_slope;
    logic                      cell_done;
    logic [MEAN_W-1:0]         mean_change;
  } result_t;

  typedef struct packed {
    logic signed [SLOPE_W-1:0] lim;
    logic [DIFF_W-1:0]         diff;
    logic                      cell_end;
  } q_entry_t;

  typedef struct packed {
    logic              full;
    logic              empty;
    logic [QCNT_W-1:0] count;
  } q_stat_t;

  typedef struct packed {
    logic signed [SLOPE_W-1:0] lim;
    logic                      cell_end;
  } div_tag_t;

  function automatic logic [SLOPE_W-1:0] mag32(input logic signed [SLOPE_W-1:0] v);
    mag32 = v[SLOPE_W-1] ? SLOPE_W'(-v) : SLOPE_W'(v);
  endfunction

endpackage

@@ src/mgl_front.sv @@
module mgl_front import mgl_pkg::*; #(
  parameter int MAX_NEIGHBORS = MAX_NEIGHBORS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_ready,
  input  item_t              item,
  input  logic [THR_W-1:0]   limit_threshold,
  input  logic [SCALE_W-1:0] neighbor_scale,
  input  q_stat_t            q_stat,
  output logic               push,
  output q_entry_t           entry
);

  localparam int NPROD_W = SLOPE_W + SCALE_W;
  localparam int THRP_W  = THR_W + SIZE_W;
  localparam int PSH_W   = NPROD_W - FRAC_W;

  function automatic logic signed [SLOPE_W-1:0] sat_scale(input logic [PSH_W-1:0] p,
                                                          input logic neg);
    logic [PSH_W-1:0] m;
    if (neg) begin
      m = (p > PSH_W'(34'h080000000)) ? PSH_W'(34'h080000000) : p;
      sat_scale = SLOPE_W'(-m);
    end else begin
      sat_scale = (p > PSH_W'(34'h07FFFFFFF)) ? 32'sh7FFFFFFF : SLOPE_W'(p);
    end
  endfunction

  logic en;
  logic v1, v2, v3, v4;

  logic signed [SLOPE_W-1:0] nbr_in [NBR_FIELDS];

  logic signed [SLOPE_W-1:0] s1_own;
  logic [SLOPE_W-1:0]        s1_own_mag;
  logic [THRP_W-1:0]         s1_thr;
  logic [NPROD_W-1:0]        s1_nprod [MAX_NEIGHBORS];
  logic [MAX_NEIGHBORS-1:0]  s1_nneg;
  logic [MAX_NEIGHBORS-1:0]  s1_pres;
  logic                      s1_end;

  logic signed [SLOPE_W-1:0] s2_own;
  logic signed [SLOPE_W-1:0] s2_cand [MAX_NEIGHBORS];
  logic [MAX_NEIGHBORS-1:0]  s2_pres;
  logic                      s2_limit;
  logic                      s2_end;

  logic signed [SLOPE_W-1:0] lo, hi;
  logic signed [SLOPE_W-1:0] s3_own, s3_lo, s3_hi;
  logic                      s3_limit;
  logic                      s3_end;

  logic signed [SLOPE_W-1:0] mm;
  logic signed [SLOPE_W-1:0] s4_own, s4_lim;
  logic                      s4_end;
  logic signed [DIFF_W-1:0]  d;

  assign nbr_in[0] = item.nbr_slope_0;
  assign nbr_in[1] = item.nbr_slope_1;
  assign nbr_in[2] = item.nbr_slope_2;
  assign nbr_in[3] = item.nbr_slope_3;
  assign nbr_in[4] = item.nbr_slope_4;
  assign nbr_in[5] = item.nbr_slope_5;

  assign en         = !(v4 && q_stat.full);
  assign item_ready = en;
  assign push       = v4 && !q_stat.full;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (en) begin
      v1 <= item_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  // stage 1: magnitudes and products
  always_ff @(posedge clk) begin
    if (en) begin
      s1_own     <= item.own_slope;
      s1_own_mag <= mag32(item.own_slope);
      s1_thr     <= THRP_W'(limit_threshold) * THRP_W'(item.cell_size);
      s1_pres    <= item.nbr_present[MAX_NEIGHBORS-1:0];
      s1_end     <= item.cell_end;
      for (int i = 0; i < MAX_NEIGHBORS; i++) begin
        s1_nprod[i] <= NPROD_W'(mag32(nbr_in[i])) * NPROD_W'(neighbor_scale);
        s1_nneg[i]  <= nbr_in[i][SLOPE_W-1];
      end
    end
  end

  // stage 2: threshold classify, saturate scaled neighbors
  always_ff @(posedge clk) begin
    if (en) begin
      s2_own   <= s1_own;
      s2_pres  <= s1_pres;
      s2_end   <= s1_end;
      s2_limit <= THRP_W'({s1_own_mag, {FRAC_W{1'b0}}}) >= s1_thr;
      for (int i = 0; i < MAX_NEIGHBORS; i++) begin
        s2_cand[i] <= sat_scale(s1_nprod[i][NPROD_W-1:FRAC_W], s1_nneg[i]);
      end
    end
  end

  // stage 3: extremes over own and present neighbors
  always_comb begin
    lo = s2_own;
    hi = s2_own;
    for (int i = 0; i < MAX_NEIGHBORS; i++) begin
      if (s2_pres[i]) begin
        if (s2_cand[i] < lo) lo = s2_cand[i];
        if (s2_cand[i] > hi) hi = s2_cand[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_own   <= s2_own;
      s3_lo    <= lo;
      s3_hi    <= hi;
      s3_limit <= s2_limit;
      s3_end   <= s2_end;
    end
  end

  // stage 4: minmod select, own slope kept when not limited
  always_comb begin
    if (s3_lo < 0 && s3_hi > 0) begin
      mm = '0;
    end else if (mag32(s3_lo) < mag32(s3_hi)) begin
      mm = s3_lo;
    end else begin
      mm = s3_hi;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_own <= s3_own;
      s4_lim <= s3_limit ? mm : s3_own;
      s4_end <= s3_end;
    end
  end

  assign d = DIFF_W'(s4_own) - DIFF_W'(s4_lim);

  always_comb begin
    entry.lim      = s4_lim;
    entry.diff     = d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
    entry.cell_end = s4_end;
  end

endmodule

@@ src/mgl_queue.sv @@
module mgl_queue import mgl_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  q_entry_t wdata,
  input  logic     pop,
  output q_entry_t rdata,
  output q_stat_t  stat
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  q_entry_t          mem [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wp, rp;
  logic [QCNT_W-1:0] count;

  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
    bump = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (push) wp <= bump(wp);
      if (pop)  rp <= bump(rp);
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= wdata;
  end

  assign rdata      = mem[rp];
  assign stat.count = count;
  assign stat.full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign stat.empty = (count == '0);

endmodule

@@ src/mgl_div.sv @@
module mgl_div import mgl_pkg::*; #(
  parameter int COMPONENT_COUNT = COMPONENT_COUNT_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  logic [SUM_W-1:0] dividend,
  input  div_tag_t         in_tag,
  output logic             out_valid,
  output logic [SUM_W-1:0] quotient,
  output div_tag_t         out_tag
);

  // quotients past the mean range saturate, so only dividends below
  // COMPONENT_COUNT * 2^31 need the exact reciprocal product
  localparam int NUM_W  = MEAN_W + 4;
  localparam int SHIFT  = NUM_W + 4;
  localparam int RCP_W  = SHIFT + 1;
  localparam int NLO_W  = NUM_W / 2;
  localparam int RLO_W  = RCP_W / 2;
  localparam int PP_W   = (NUM_W - NLO_W) + (RCP_W - RLO_W);
  localparam int PROD_W = NUM_W + RCP_W;

  localparam logic [RCP_W-1:0] RECIP =
    RCP_W'(((64'd1 << SHIFT) + 64'(COMPONENT_COUNT) - 64'd1) / 64'(COMPONENT_COUNT));
  localparam logic [SUM_W-1:0]       SAT_LIMIT = SUM_W'(64'(COMPONENT_COUNT) << MEAN_W);
  localparam logic [RCP_W-RLO_W-1:0] RCP_HI    = RECIP[RCP_W-1:RLO_W];
  localparam logic [RLO_W-1:0]       RCP_LO    = RECIP[RLO_W-1:0];

  logic [NUM_W-1:0]  num;
  logic              a_valid, a_sat;
  logic [PP_W-1:0]   pp_hh, pp_hl, pp_lh, pp_ll;
  div_tag_t          a_tag;
  logic [PROD_W-1:0] prod;
  logic              b_valid;
  logic [SUM_W-1:0]  b_quot;
  div_tag_t          b_tag;

  assign num = dividend[NUM_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
    end else if (en) begin
      a_valid <= in_valid;
      b_valid <= a_valid;
    end
  end

  // stage 1: range check, partial products against the reciprocal
  always_ff @(posedge clk) begin
    if (en) begin
      a_sat <= dividend >= SAT_LIMIT;
      a_tag <= in_tag;
      pp_hh <= PP_W'(num[NUM_W-1:NLO_W]) * PP_W'(RCP_HI);
      pp_hl <= PP_W'(num[NUM_W-1:NLO_W]) * PP_W'(RCP_LO);
      pp_lh <= PP_W'(num[NLO_W-1:0]) * PP_W'(RCP_HI);
      pp_ll <= PP_W'(num[NLO_W-1:0]) * PP_W'(RCP_LO);
    end
  end

  assign prod = (PROD_W'(pp_hh) << (NLO_W + RLO_W)) + (PROD_W'(pp_hl) << NLO_W)
              + (PROD_W'(pp_lh) << RLO_W) + PROD_W'(pp_ll);

  // stage 2: sum and drop the reciprocal scale; saturated dividends give all ones
  always_ff @(posedge clk) begin
    if (en) begin
      b_tag  <= a_tag;
      b_quot <= a_sat ? '1 : SUM_W'(prod[PROD_W-1:SHIFT]);
    end
  end

  assign out_valid = b_valid;
  assign quotient  = b_quot;
  assign out_tag   = b_tag;

endmodule

@@ src/mgl_back.sv @@
module mgl_back import mgl_pkg::*; #(
  parameter int COMPONENT_COUNT = COMPONENT_COUNT_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  q_entry_t entry,
  input  q_stat_t  q_stat,
  output logic     pop,
  output logic     result_valid,
  input  logic     result_ready,
  output result_t  result
);

  logic             b_en;
  logic [SUM_W-1:0] change_sum;
  logic [SUM_W:0]   tot;
  logic [SUM_W-1:0] sat;

  logic             b1_valid;
  logic [SUM_W-1:0] b1_sum;
  div_tag_t         b1_tag;

  logic             d_valid;
  logic [SUM_W-1:0] quot;
  div_tag_t         d_tag;

  assign b_en = !result_valid || result_ready;
  assign pop  = b_en && !q_stat.empty;

  assign tot = {1'b0, change_sum} + (SUM_W + 1)'(entry.diff);
  assign sat = tot[SUM_W] ? '1 : tot[SUM_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      change_sum <= '0;
      b1_valid   <= 1'b0;
    end else if (b_en) begin
      b1_valid <= !q_stat.empty;
      if (pop) change_sum <= entry.cell_end ? '0 : sat;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      b1_sum          <= sat;
      b1_tag.lim      <= entry.lim;
      b1_tag.cell_end <= entry.cell_end;
    end
  end

  mgl_div #(
    .COMPONENT_COUNT(COMPONENT_COUNT)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (b_en),
    .in_valid (b1_valid),
    .dividend (b1_sum),
    .in_tag   (b1_tag),
    .out_valid(d_valid),
    .quotient (quot),
    .out_tag  (d_tag)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (b_en) begin
      result_valid <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (b_en) begin
      result.limited_slope <= d_tag.lim;
      result.cell_done     <= d_tag.cell_end;
      if (!d_tag.cell_end) begin
        result.mean_change <= '0;
      end else if (quot[SUM_W-1:MEAN_W] != '0) begin
        result.mean_change <= '1;
      end else begin
        result.mean_change <= quot[MEAN_W-1:0];
      end
    end
  end

endmodule

@@ src/minmod_gradient_limiter_core.sv @@
// From item transaction to result valid, an item passes the 4-stage front
// (first stage on the accepting edge), the queue write, the sum register, the
// 2-stage reciprocal divide and the output register; result stalls delay it.
// Throughput: one item per cycle unless stalled; front and back stall apart
// via the 4-entry queue. Reset (rst, synchronous): pipelines and queue empty,
// change sum 0, limit_threshold 0, neighbor_scale 1.0.
`include "minmod_gradient_limiter_core_defines.svh"

module minmod_gradient_limiter_core import mgl_pkg::*; #(
  parameter int MAX_NEIGHBORS   = MAX_NEIGHBORS_DEF,
  parameter int COMPONENT_COUNT = COMPONENT_COUNT_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  input  logic               item_valid,
  output logic               item_ready,
  input  item_t              item,
  output logic               result_valid,
  input  logic               result_ready,
  output result_t            result
);

  logic [THR_W-1:0]   limit_threshold;
  logic [SCALE_W-1:0] neighbor_scale;
  logic               wr;

  logic     push, pop;
  q_entry_t q_wdata, q_rdata;
  q_stat_t  q_stat;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      limit_threshold <= THRESHOLD_RESET;
      neighbor_scale  <= SCALE_RESET;
    end else if (wr) begin
      unique case (paddr[REG_IDX_LSB])
        REG_LIMIT_THRESHOLD: limit_threshold <= pwdata[THR_W-1:0];
        REG_NEIGHBOR_SCALE:  neighbor_scale  <= pwdata[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[REG_IDX_LSB])
      REG_LIMIT_THRESHOLD: prdata = PDATA_W'(limit_threshold);
      REG_NEIGHBOR_SCALE:  prdata = PDATA_W'(neighbor_scale);
      default:             prdata = '0;
    endcase
  end

  mgl_front #(
    .MAX_NEIGHBORS(MAX_NEIGHBORS)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .item_valid     (item_valid),
    .item_ready     (item_ready),
    .item           (item),
    .limit_threshold(limit_threshold),
    .neighbor_scale (neighbor_scale),
    .q_stat         (q_stat),
    .push           (push),
    .entry          (q_wdata)
  );

  mgl_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .wdata(q_wdata),
    .pop  (pop),
    .rdata(q_rdata),
    .stat (q_stat)
  );

  mgl_back #(
    .COMPONENT_COUNT(COMPONENT_COUNT)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .entry       (q_rdata),
    .q_stat      (q_stat),
    .pop         (pop),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result      (result)
  );

  `MGL_ASSERT_NOW(a_queue_bound, 1'b1, q_stat.count <= QCNT_W'(QUEUE_DEPTH))
  `MGL_ASSERT_NOW(a_stall_from_queue, !item_ready, q_stat.full)
  `MGL_ASSERT_NEXT(a_queue_fills, push && !pop && q_stat.count == QCNT_W'(QUEUE_DEPTH-1), q_stat.full)
  `MGL_ASSERT_NOW(a_mean_only_at_end, result_valid && !result.cell_done, result.mean_change == '0)

endmodule
